[sv/vector_register_elementwise_unit_top_macros.svh]
// Assertion macros used by the sequencer RTL file of the vector register unit.
`ifndef VECTOR_REGISTER_ELEMENTWISE_UNIT_TOP_MACROS_SVH
`define VECTOR_REGISTER_ELEMENTWISE_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define VREU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define VREU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/vreu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vreu_pkg;

	localparam int NUM_REGS      = 16;
	localparam int MAX_BYTES     = 256;
	localparam int WORD_BYTES    = 8;
	localparam int WORDS_PER_REG = MAX_BYTES / WORD_BYTES;
	localparam int WIDX_W        = $clog2(WORDS_PER_REG);
	localparam int NW_W          = WIDX_W + 1;
	localparam int REG_W         = 4;
	localparam int SLOT_W        = 4;
	localparam int SIZE_W        = 9;
	localparam int ADDR_W        = SLOT_W + WIDX_W;
	localparam int RAM_DEPTH     = NUM_REGS * WORDS_PER_REG;

	typedef enum logic [2:0] {
		CMD_ALLOC, CMD_FILL, CMD_SWAP, CMD_COPY,
		CMD_SPLIT, CMD_ELEM, CMD_READ, CMD_WRITE
	} cmd_e;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR,
		OP_XOR, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE, OP_GE
	} alu_op_e;

	typedef enum logic [2:0] {
		ST_OK, ST_EMPTY, ST_COPY_SMALL, ST_SPLIT_LARGE,
		ST_SPLIT_SMALL, ST_TOO_BIG, ST_BAD_INDEX
	} status_e;

	typedef enum logic [3:0] {
		S_IDLE, S_MA, S_MB, S_CHK, S_R0, S_R1, S_R2, S_R3,
		S_CMP, S_LANE, S_LWAIT, S_WR, S_WA, S_WB, S_FIN
	} seq_state_e;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [1:0]  lane_width;
		logic [3:0]  alu_op;
		logic [8:0]  amount;
		logic [63:0] value;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  size_a;
		logic [8:0]  capacity_a;
		logic [63:0] read_value;
	} rsp_word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [SIZE_W-1:0] used;
		logic [SIZE_W-1:0] cap;
	} meta_ent_t;

	typedef struct packed {
		logic              en;
		logic [REG_W-1:0]  addr;
		meta_ent_t         ent;
	} meta_wr_t;

	function automatic logic [63:0] lane_mask(input logic [1:0] lw);
		logic [63:0] m;
		unique case (lw)
			2'd0: m = 64'h0000_0000_0000_00ff;
			2'd1: m = 64'h0000_0000_0000_ffff;
			2'd2: m = 64'h0000_0000_ffff_ffff;
			2'd3: m = '1;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] lane_bytes(input logic [1:0] lw);
		return 4'd1 << lw;
	endfunction

endpackage
`default_nettype wire

[sv/vreu_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module vreu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/vreu_meta.sv]
`timescale 1ns / 1ps
`default_nettype none
module vreu_meta import vreu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [REG_W-1:0] raddr,
	output meta_ent_t             rdata,
	input  wire meta_wr_t         wr
);

	meta_ent_t meta_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				meta_q[i].slot <= SLOT_W'(i);
				meta_q[i].used <= '0;
				meta_q[i].cap  <= '0;
			end
		end else if (wr.en) begin
			meta_q[wr.addr] <= wr.ent;
		end
	end

	assign rdata = meta_q[raddr];

endmodule
`default_nettype wire

[sv/vreu_lane_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
module vreu_lane_alu import vreu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [3:0]  op,
	input  wire logic [1:0]  lw,
	input  wire logic [63:0] x,
	input  wire logic [63:0] y,
	output logic             done,
	output logic [63:0]      result
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [3:0]  op_q;
	logic [1:0]  lw_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic [63:0] mx_q;
	logic [63:0] my_q;
	logic [63:0] res_q;

	logic        iter;
	logic [6:0]  bits;
	logic [63:0] simple;
	logic [63:0] acc_nxt;
	logic [64:0] t;
	logic        ge;
	logic [64:0] tsub;
	logic [63:0] rem_nxt;
	logic [63:0] q_nxt;
	logic [63:0] fin;

	assign iter = (op == OP_MUL) || (op == OP_DIV) || (op == OP_REM);
	assign bits = 7'd8 << lw;

	always_comb begin
		unique case (op)
			OP_ADD:  simple = x + y;
			OP_SUB:  simple = x - y;
			OP_AND:  simple = x & y;
			OP_OR:   simple = x | y;
			OP_XOR:  simple = x ^ y;
			OP_EQ:   simple = {63'd0, x == y};
			OP_NE:   simple = {63'd0, x != y};
			OP_LT:   simple = {63'd0, x < y};
			OP_GT:   simple = {63'd0, x > y};
			OP_LE:   simple = {63'd0, x <= y};
			OP_GE:   simple = {63'd0, x >= y};
			default: simple = '0;
		endcase
	end

	assign acc_nxt = my_q[0] ? acc_q + mx_q : acc_q;
	assign t       = {rem_q, mx_q[63]};
	assign ge      = t >= {1'b0, my_q};
	assign tsub    = t - {1'b0, my_q};
	assign rem_nxt = ge ? tsub[63:0] : t[63:0];
	assign q_nxt   = {acc_q[62:0], ge};

	always_comb begin
		if (op_q == OP_MUL) begin
			fin = acc_nxt;
		end else if (op_q == OP_DIV) begin
			fin = q_nxt;
		end else begin
			fin = rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= iter;
				done_q <= !iter;
			end else if (busy_q && cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			lw_q  <= lw;
			cnt_q <= bits;
			acc_q <= '0;
			rem_q <= '0;
			mx_q  <= (op == OP_MUL) ? x : x << (7'd64 - bits);
			my_q  <= y;
			res_q <= simple & lane_mask(lw);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			mx_q  <= mx_q << 1;
			if (op_q == OP_MUL) begin
				acc_q <= acc_nxt;
				my_q  <= my_q >> 1;
			end else begin
				acc_q <= q_nxt;
				rem_q <= rem_nxt;
			end
			if (cnt_q == 7'd1) begin
				res_q <= fin & lane_mask(lw_q);
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

[sv/vreu_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "vector_register_elementwise_unit_top_macros.svh"
module vreu_seq import vreu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_word_t         req,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output rsp_word_t              res,
	output logic [REG_W-1:0]       meta_raddr,
	input  wire meta_ent_t         meta_rdata,
	output meta_wr_t               meta_wr,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output logic [63:0]            ram_wdata,
	output logic [ADDR_W-1:0]      ram_raddr,
	input  wire logic [63:0]       ram_rdata
);

	seq_state_e state_q, state_d, chk_next;

	req_word_t         req_q;
	meta_ent_t         ma_q, mb_q;
	status_e           st_q, st_d;
	logic              bad_q, bad_d;
	logic [SIZE_W-1:0] lim_q, lim_d;
	logic [NW_W-1:0]   nw_q, nw_d;
	logic [NW_W-1:0]   w_q;
	logic [63:0]       d0_q, d1_q, d2_q;
	logic [63:0]       word_q;
	logic [63:0]       rd_q;
	logic [3:0]        boff_q;

	logic [3:0]        lb;
	logic [SIZE_W-1:0] lb9;
	logic [63:0]       lbm;
	logic [63:0]       val_m;
	logic [SIZE_W-1:0] nb_fill, umin, nb_elem, len;
	logic [11:0]       rw_off;
	logic [12:0]       rw_end;
	logic [WIDX_W-1:0] wi, sw, sw1, rw_widx;
	logic [NW_W-1:0]   sw_full;
	logic              is_split, is_copy;
	logic [ADDR_W-1:0] a0, a1, a2;
	logic [63:0]       old, pat, shw, wdat, merged, ext_rd;
	logic [127:0]      cat;
	logic [7:0]        bm, wbm;
	logic              lane_ok;
	logic [5:0]        lsh;
	logic [63:0]       alu_x, alu_y, alu_res;
	logic              alu_start, alu_done;
	meta_wr_t          wa_wr, wb_wr;
	logic              loop;

	assign lb      = lane_bytes(req_q.lane_width);
	assign lb9     = SIZE_W'(lb);
	assign lbm     = lane_mask(req_q.lane_width);
	assign val_m   = req_q.value & lbm;
	assign nb_fill = ma_q.used & ~(lb9 - SIZE_W'(1));
	assign umin    = (ma_q.used < mb_q.used) ? ma_q.used : mb_q.used;
	assign nb_elem = umin & ~(lb9 - SIZE_W'(1));
	assign len     = ma_q.used - req_q.amount;
	assign rw_off  = 12'(req_q.amount) << req_q.lane_width;
	assign rw_end  = 13'(rw_off) + 13'(lb);
	assign rw_widx = rw_off[WIDX_W+2:3];
	assign wi      = w_q[WIDX_W-1:0];
	assign sw_full = NW_W'(req_q.amount >> 3) + w_q;
	assign sw      = sw_full[WIDX_W-1:0];
	assign sw1     = sw + WIDX_W'(1);
	assign is_split = req_q.cmd == CMD_SPLIT;
	assign is_copy  = req_q.cmd == CMD_COPY;

	always_comb begin
		if (is_split) begin
			a0 = {ma_q.slot, sw};
		end else if (req_q.cmd == CMD_READ || req_q.cmd == CMD_WRITE) begin
			a0 = {ma_q.slot, rw_widx};
		end else begin
			a0 = {ma_q.slot, wi};
		end
		if (is_split) begin
			a1 = {ma_q.slot, sw1};
		end else if (req_q.cmd == CMD_ELEM) begin
			a1 = {mb_q.slot, wi};
		end else begin
			a1 = a0;
		end
		a2 = (is_split || is_copy) ? {mb_q.slot, wi} : a0;
	end

	// Command checks and loop bounds, from the two fetched register entries.
	always_comb begin
		st_d     = ST_OK;
		bad_d    = (REG_W + 1)'(req_q.reg_a) >= (REG_W + 1)'(NUM_REGS) ||
			(REG_W + 1)'(req_q.reg_b) >= (REG_W + 1)'(NUM_REGS);
		lim_d    = '0;
		loop     = 1'b0;
		chk_next = S_FIN;
		nw_d     = '0;
		if (bad_d) begin
			st_d = ST_BAD_INDEX;
		end else begin
			unique case (req_q.cmd)
				CMD_ALLOC: begin
					if (req_q.amount > SIZE_W'(MAX_BYTES)) begin
						st_d = ST_TOO_BIG;
					end else begin
						lim_d = req_q.amount;
						loop  = 1'b1;
					end
				end
				CMD_FILL: begin
					if (ma_q.used == '0) begin
						st_d = ST_EMPTY;
					end else begin
						lim_d = nb_fill;
						loop  = 1'b1;
					end
				end
				CMD_SWAP: begin
					chk_next = S_WA;
				end
				CMD_COPY: begin
					if (mb_q.cap < ma_q.used) begin
						st_d = ST_COPY_SMALL;
					end else begin
						lim_d = ma_q.used;
						loop  = 1'b1;
					end
				end
				CMD_SPLIT: begin
					if (req_q.amount > ma_q.used) begin
						st_d = ST_SPLIT_LARGE;
					end else if ((SIZE_W + 1)'(mb_q.cap) + (SIZE_W + 1)'(req_q.amount) <
						(SIZE_W + 1)'(ma_q.used)) begin
						st_d = ST_SPLIT_SMALL;
					end else begin
						lim_d = len;
						loop  = 1'b1;
					end
				end
				CMD_ELEM: begin
					if (req_q.alu_op <= OP_GE) begin
						lim_d = nb_elem;
						loop  = 1'b1;
					end
				end
				CMD_READ, CMD_WRITE: begin
					if (rw_end > 13'(ma_q.used)) begin
						st_d = ST_BAD_INDEX;
					end else begin
						loop = 1'b1;
					end
				end
			endcase
		end
		if (req_q.cmd == CMD_READ || req_q.cmd == CMD_WRITE) begin
			nw_d = NW_W'(1);
		end else begin
			nw_d = NW_W'(((SIZE_W + 1)'(lim_d) + (SIZE_W + 1)'(7)) >> 3);
		end
		if (loop) begin
			chk_next = (nw_d == '0) ? S_WA : S_R0;
		end
	end

	// Word merge for the byte-oriented commands.
	assign old = (is_split || is_copy) ? d2_q : d0_q;
	assign cat = {d1_q, d0_q};
	assign shw = cat[{req_q.amount[2:0], 3'b000} +: 64];
	assign wdat   = val_m << {rw_off[2:0], 3'b000};
	assign ext_rd = (d0_q >> {rw_off[2:0], 3'b000}) & lbm;

	always_comb begin
		unique case (req_q.lane_width)
			2'd0: pat = {8{val_m[7:0]}};
			2'd1: pat = {4{val_m[15:0]}};
			2'd2: pat = {2{val_m[31:0]}};
			2'd3: pat = val_m;
		endcase
		for (int k = 0; k < 8; k++) begin
			bm[k]  = SIZE_W'({wi, 3'(k)}) < lim_q;
			wbm[k] = (4'(k) >= 4'(rw_off[2:0])) && (4'(k) < 4'(rw_off[2:0]) + lb);
			unique case (req_q.cmd)
				CMD_ALLOC: merged[8*k +: 8] = bm[k] ? 8'd0 : old[8*k +: 8];
				CMD_FILL:  merged[8*k +: 8] = bm[k] ? pat[8*k +: 8] : old[8*k +: 8];
				CMD_COPY:  merged[8*k +: 8] = bm[k] ? d0_q[8*k +: 8] : old[8*k +: 8];
				CMD_SPLIT: merged[8*k +: 8] = bm[k] ? shw[8*k +: 8] : old[8*k +: 8];
				CMD_WRITE: merged[8*k +: 8] = wbm[k] ? wdat[8*k +: 8] : old[8*k +: 8];
				default:   merged[8*k +: 8] = old[8*k +: 8];
			endcase
		end
	end

	assign lsh     = {boff_q[2:0], 3'b000};
	assign lane_ok = !boff_q[3] && (SIZE_W'({wi, boff_q[2:0]}) < lim_q);
	assign alu_x   = (d0_q >> lsh) & lbm;
	assign alu_y   = (d1_q >> lsh) & lbm;

	vreu_lane_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.op     (req_q.alu_op),
		.lw     (req_q.lane_width),
		.x      (alu_x),
		.y      (alu_y),
		.done   (alu_done),
		.result (alu_res)
	);

	always_comb begin
		wa_wr = '0;
		wb_wr = '0;
		unique case (req_q.cmd)
			CMD_ALLOC: begin
				wa_wr.en  = 1'b1;
				wa_wr.addr = req_q.reg_a;
				wa_wr.ent = '{slot: ma_q.slot, used: req_q.amount, cap: req_q.amount};
			end
			CMD_SWAP: begin
				wa_wr.en   = 1'b1;
				wa_wr.addr = req_q.reg_a;
				wa_wr.ent  = mb_q;
				wb_wr.en   = 1'b1;
				wb_wr.addr = req_q.reg_b;
				wb_wr.ent  = ma_q;
			end
			CMD_COPY: begin
				wa_wr.en   = 1'b1;
				wa_wr.addr = req_q.reg_b;
				wa_wr.ent  = '{slot: mb_q.slot, used: ma_q.used, cap: mb_q.cap};
			end
			CMD_SPLIT: begin
				wa_wr.en   = 1'b1;
				wa_wr.addr = req_q.reg_a;
				wa_wr.ent  = '{slot: ma_q.slot, used: req_q.amount, cap: ma_q.cap};
				wb_wr.en   = 1'b1;
				wb_wr.addr = req_q.reg_b;
				wb_wr.ent  = '{slot: mb_q.slot, used: len, cap: mb_q.cap};
			end
			default: begin
				wa_wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		res_valid  = 1'b0;
		alu_start  = 1'b0;
		ram_we     = 1'b0;
		meta_wr    = '0;
		meta_raddr = req_q.reg_a;
		ram_raddr  = a0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = S_MA;
				end
			end
			S_MA: state_d = S_MB;
			S_MB: begin
				meta_raddr = req_q.reg_b;
				state_d    = S_CHK;
			end
			S_CHK: state_d = chk_next;
			S_R0: state_d = S_R1;
			S_R1: begin
				ram_raddr = a1;
				state_d   = S_R2;
			end
			S_R2: begin
				ram_raddr = a2;
				state_d   = S_R3;
			end
			S_R3: state_d = S_CMP;
			S_CMP: begin
				if (req_q.cmd == CMD_READ) begin
					state_d = S_WA;
				end else if (req_q.cmd == CMD_ELEM) begin
					state_d = S_LANE;
				end else begin
					state_d = S_WR;
				end
			end
			S_LANE: begin
				if (lane_ok) begin
					alu_start = 1'b1;
					state_d   = S_LWAIT;
				end else begin
					state_d = S_WR;
				end
			end
			S_LWAIT: begin
				if (alu_done) begin
					state_d = S_LANE;
				end
			end
			S_WR: begin
				ram_we  = 1'b1;
				state_d = (w_q + NW_W'(1) == nw_q) ? S_WA : S_R0;
			end
			S_WA: begin
				meta_wr = wa_wr;
				state_d = S_WB;
			end
			S_WB: begin
				meta_wr = wb_wr;
				state_d = S_FIN;
			end
			S_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
					rd_q  <= '0;
				end
			end
			S_MA: ma_q <= meta_rdata;
			S_MB: mb_q <= meta_rdata;
			S_CHK: begin
				st_q  <= st_d;
				bad_q <= bad_d;
				lim_q <= lim_d;
				nw_q  <= nw_d;
				w_q   <= '0;
			end
			S_R1: d0_q <= ram_rdata;
			S_R2: d1_q <= ram_rdata;
			S_R3: d2_q <= ram_rdata;
			S_CMP: begin
				if (req_q.cmd == CMD_READ) begin
					rd_q <= ext_rd;
				end
				word_q <= merged;
				boff_q <= '0;
			end
			S_LWAIT: begin
				if (alu_done) begin
					word_q <= (word_q & ~(lbm << lsh)) | (alu_res << lsh);
					boff_q <= boff_q + lb;
				end
			end
			S_WR: w_q <= w_q + NW_W'(1);
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	assign ram_waddr = a2;
	assign ram_wdata = word_q;

	always_comb begin
		res.status     = st_q;
		res.size_a     = bad_q ? '0 : meta_rdata.used;
		res.capacity_a = bad_q ? '0 : meta_rdata.cap;
		res.read_value = rd_q;
	end

	`VREU_ASSERT_IMP(a_ram_we_step, ram_we, state_q == S_WR, "store write outside write step")
	`VREU_ASSERT_IMP(a_word_bound, state_q == S_R0, w_q < nw_q, "word index past count")
	`VREU_ASSERT_IMP(a_alu_done, alu_done, state_q == S_LWAIT, "lane result while not waiting")
	`VREU_ASSERT_NXT(a_fin_hold, state_q == S_FIN && !res_ready, state_q == S_FIN, "result dropped")

endmodule
`default_nettype wire

[sv/vector_register_elementwise_unit_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Vector register unit: sixteen byte registers of up to 256 bytes, whose data sits in one
// 512 x 64-bit store with a registered read; register sizes, capacities and the slot
// map live in a small flip-flop table. Commands are taken one at a time and each gives one
// result word. A command passes through control steps (accept, two table reads, check,
// result), two table-write steps when its checks pass, and for every 64-bit store word it
// touches three reads, merge and write (reading an element skips the write). Element-wise
// operations add a lane step per word and, per lane, a start and a wait on the lane unit;
// multiply, divide and remainder run one bit a cycle in a shared lane unit. Swap touches
// no store words. While a result waits at the output register the next command word can
// already be accepted.
module vector_register_elementwise_unit_top import vreu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp
);

	logic              res_valid, res_ready;
	rsp_word_t         res;
	logic [REG_W-1:0]  meta_raddr;
	meta_ent_t         meta_rdata;
	meta_wr_t          meta_wr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [63:0]       ram_wdata, ram_rdata;
	logic              rsp_valid_q;
	rsp_word_t         rsp_q;

	vreu_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.meta_raddr (meta_raddr),
		.meta_rdata (meta_rdata),
		.meta_wr    (meta_wr),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	vreu_meta u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (meta_raddr),
		.rdata  (meta_rdata),
		.wr     (meta_wr)
	);

	vreu_ram #(
		.WIDTH (64),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
